// File: rtl/core/lfo_pkg.sv
package lfo_pkg;

   typedef enum logic [1:0] {
      CMD_PUT     = 2'd0,
      CMD_GET     = 2'd1,
      CMD_FLUSH   = 2'd2,
      CMD_CLR_OVF = 2'd3
   } cmd_type;

   typedef enum logic {
      ST_IDLE,
      ST_GET
   } state_type;

   // register indexes on the csr channel
   localparam logic [1:0] CSR_CAPACITY = 2'd0;
   localparam logic [1:0] CSR_LINES    = 2'd1;
   localparam logic [1:0] CSR_LOCK     = 2'd2;

   localparam logic [6:0] CAPACITY_RESET = 7'd64;
   localparam logic [4:0] LINES_RESET    = 5'd10;

   typedef struct packed {
      logic [7:0] out_byte;
      logic [6:0] read_length;
      logic       last;
      logic       accepted;
      logic [4:0] line_total;
      logic       overflow;
   } rsp_type;

endpackage

// File: rtl/core/line_fifo_overwrite_unit.sv
// Line FIFO with overwrite. A ring of up to MAX_LINES lines of up to MAX_LINE_BYTES bytes each,
// held in one line memory plus a small length table. A put byte, a flush and a clear-overflow
// each give one result beat. A get of a stored line of N bytes streams N beats, one per cycle
// while the result queue has room, through the single read port of the line memory; the get
// first loads the read state, then each byte passes a read register before the result queue,
// and the next command is taken once the final byte has entered the result queue. A get of an
// empty ring, of a zero-length line or of a line longer than the current capacity gives one
// beat. A two-entry result queue lets the block take the next command while a result beat is
// still waiting. The line memory needs no clearing after reset. Configuration is to be written
// only while idle, a rule for the user that the block itself does not enforce.
module line_fifo_overwrite_unit
   import lfo_pkg::*;
#(
   parameter int MAX_LINE_BYTES = 64,
   parameter int MAX_LINES      = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // data_byte[7:0], line_length[15:8]
   input  logic [1:0]  req_tuser,   // cmd[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // out_byte[7:0], read_length[14:8], line_total[19:15],
                                    // overflow[20], zero[23:21]
   output logic        rsp_tlast,   // last
   output logic [0:0]  rsp_tuser,   // accepted[0]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [6:0]  csr_data
);

   localparam int BYTE_W = $clog2(MAX_LINE_BYTES);
   localparam int LINE_W = $clog2(MAX_LINES);
   localparam int CNT_W  = $clog2(MAX_LINES + 1);
   localparam int DEPTH  = MAX_LINES * MAX_LINE_BYTES;
   localparam int ADDR_W = $clog2(DEPTH);

   function automatic logic [LINE_W-1:0] advance(input logic [LINE_W-1:0] idx,
                                                 input logic [CNT_W-1:0] lim);
      logic [CNT_W-1:0] nxt;
      nxt = CNT_W'(idx) + 1'b1;
      return (nxt >= lim) ? '0 : LINE_W'(nxt);
   endfunction

   function automatic logic [4:0] to_total(input logic [CNT_W-1:0] q);
      logic [31:0] w;
      w = 32'(q);
      return w[4:0];
   endfunction

   // configuration
   logic [6:0] cap_ff;
   logic [4:0] lines_ff;
   logic       lock_ff;

   // ring state
   logic [LINE_W-1:0] head_ff, head_in;
   logic [LINE_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0]  queued_ff, queued_in;
   logic              ovf_ff, ovf_in;
   logic [7:0]        pbi_ff, pbi_in;
   logic              padm_ff, padm_in;

   // get streaming
   state_type         state_ff, state_in;
   logic [BYTE_W-1:0] get_idx_ff;
   logic [7:0]        get_len_ff;
   logic [LINE_W-1:0] get_slot_ff;
   logic              rd_valid_ff;
   logic              rd_last_ff;
   logic [7:0]        rd_data_ff;

   // result queue
   rsp_type    fifo_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;

   logic [7:0] line_mem [DEPTH];
   logic [7:0] len_mem [MAX_LINES];

   cmd_type           cmd;
   logic [7:0]        data_byte, line_length;
   logic              accept, pop, push;
   logic [7:0]        cap_eff;
   logic [CNT_W-1:0]  lc;
   logic [7:0]        stored;
   logic [LINE_W-1:0] tail_adv;
   logic [CNT_W-1:0]  free_cnt;
   logic [CNT_W:0]    q_inc;
   logic              admit, final_byte;
   logic              line_we, len_we, acc, get_go, imm_push;
   logic              rd_issue, rd_is_last;
   logic [2:0]        occ_next;
   logic [ADDR_W-1:0] waddr, raddr;
   rsp_type           imm_entry, push_entry, head_entry;

   assign cmd         = cmd_type'(req_tuser);
   assign data_byte   = req_tdata[7:0];
   assign line_length = req_tdata[15:8];
   assign accept      = req_tvalid && req_tready;
   assign pop         = rsp_tvalid && rsp_tready;
   assign csr_ready   = 1'b1;

   always_comb begin
      if (cap_ff < 7'd2) begin
         cap_eff = 8'd2;
      end else if ({1'b0, cap_ff} > 8'(MAX_LINE_BYTES)) begin
         cap_eff = 8'(MAX_LINE_BYTES);
      end else begin
         cap_eff = {1'b0, cap_ff};
      end
   end

   always_comb begin
      if (lines_ff < 5'd2) begin
         lc = CNT_W'(2);
      end else if (32'(lines_ff) > MAX_LINES) begin
         lc = CNT_W'(MAX_LINES);
      end else begin
         lc = CNT_W'(lines_ff);
      end
   end

   assign stored     = len_mem[tail_ff];
   assign tail_adv   = advance(tail_ff, lc);
   assign free_cnt   = (tail_adv == head_ff) ? '0 : queued_ff - 1'b1;
   assign q_inc      = {1'b0, queued_ff} + 1'b1;
   assign admit      = (pbi_ff == 8'd0) ?
                       ((line_length <= cap_eff) && !(lock_ff && (queued_ff >= lc))) : padm_ff;
   assign final_byte = (9'(pbi_ff) + 9'd1) >= 9'(line_length);
   assign waddr      = ADDR_W'(head_ff) * ADDR_W'(MAX_LINE_BYTES) + ADDR_W'(pbi_ff);

   // command decode and ring update
   always_comb begin
      head_in   = head_ff;
      tail_in   = tail_ff;
      queued_in = queued_ff;
      ovf_in    = ovf_ff;
      pbi_in    = pbi_ff;
      padm_in   = padm_ff;
      line_we   = 1'b0;
      len_we    = 1'b0;
      acc       = 1'b0;
      get_go    = 1'b0;
      if (accept) begin
         case (cmd)
            CMD_PUT: begin
               line_we = admit && (9'(pbi_ff) < 9'(MAX_LINE_BYTES)) && (line_length != 8'd0);
               if (final_byte) begin
                  if (admit) begin
                     len_we = 1'b1;
                     // ring full: the oldest line gets overwritten
                     if ((queued_ff != '0) && (head_ff == tail_ff)) begin
                        tail_in = tail_adv;
                     end
                     head_in = advance(head_ff, lc);
                     if (q_inc > {1'b0, lc}) begin
                        queued_in = lc;
                        ovf_in    = 1'b1;
                     end else begin
                        queued_in = CNT_W'(q_inc);
                     end
                     acc = 1'b1;
                  end
                  pbi_in  = 8'd0;
                  padm_in = 1'b0;
               end else begin
                  pbi_in  = pbi_ff + 8'd1;
                  padm_in = admit;
               end
            end
            CMD_GET: begin
               if (queued_ff != '0) begin
                  tail_in   = tail_adv;
                  queued_in = free_cnt;
                  if (free_cnt == '0) begin
                     ovf_in = 1'b0;
                  end
                  get_go = !((stored > cap_eff) || (stored == 8'd0));
               end
            end
            CMD_FLUSH: begin
               head_in   = '0;
               tail_in   = '0;
               queued_in = '0;
               ovf_in    = 1'b0;
               pbi_in    = 8'd0;
               padm_in   = 1'b0;
            end
            default: begin
               ovf_in = 1'b0;
            end
         endcase
      end
   end

   assign occ_next   = 3'(count_ff) + 3'(rd_valid_ff) - 3'(pop);
   assign rd_is_last = (9'(get_idx_ff) + 9'd1) == 9'(get_len_ff);
   assign raddr      = ADDR_W'(get_slot_ff) * ADDR_W'(MAX_LINE_BYTES) + ADDR_W'(get_idx_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && get_go) begin
               state_in = ST_GET;
            end
         end
         ST_GET: begin
            if (rd_issue && rd_is_last) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_tready = 1'b0;
      rd_issue   = 1'b0;
      case (state_ff)
         ST_IDLE: req_tready = !rd_valid_ff && (count_ff < 2'd2);
         ST_GET:  rd_issue   = occ_next < 3'd2;
         default: req_tready = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff   <= CAPACITY_RESET;
         lines_ff <= LINES_RESET;
         lock_ff  <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_CAPACITY: cap_ff   <= csr_data;
            CSR_LINES:    lines_ff <= csr_data[4:0];
            CSR_LOCK:     lock_ff  <= csr_data[0];
            default:      ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff     <= '0;
         tail_ff     <= '0;
         queued_ff   <= '0;
         ovf_ff      <= 1'b0;
         pbi_ff      <= 8'd0;
         padm_ff     <= 1'b0;
         state_ff    <= ST_IDLE;
         rd_valid_ff <= 1'b0;
         rd_last_ff  <= 1'b0;
      end else begin
         head_ff     <= head_in;
         tail_ff     <= tail_in;
         queued_ff   <= queued_in;
         ovf_ff      <= ovf_in;
         pbi_ff      <= pbi_in;
         padm_ff     <= padm_in;
         state_ff    <= state_in;
         rd_valid_ff <= rd_issue;
         rd_last_ff  <= rd_issue && rd_is_last;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && get_go) begin
         get_idx_ff  <= '0;
         get_len_ff  <= stored;
         get_slot_ff <= tail_ff;
      end else if (rd_issue) begin
         get_idx_ff <= get_idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (line_we) begin
         line_mem[waddr] <= data_byte;
      end
      if (rd_issue) begin
         rd_data_ff <= line_mem[raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (len_we) begin
         len_mem[head_ff] <= line_length;
      end
   end

   // result beats: read data of a get stream, or the single beat of any other step
   assign imm_push = accept && !get_go;
   assign push     = rd_valid_ff || imm_push;

   always_comb begin
      imm_entry             = '0;
      imm_entry.last        = 1'b1;
      imm_entry.accepted    = acc;
      imm_entry.line_total  = to_total(queued_in);
      imm_entry.overflow    = ovf_in;
      if (rd_valid_ff) begin
         push_entry.out_byte    = rd_data_ff;
         push_entry.read_length = get_len_ff[6:0];
         push_entry.last        = rd_last_ff;
         push_entry.accepted    = 1'b0;
         push_entry.line_total  = to_total(queued_ff);
         push_entry.overflow    = ovf_ff;
      end else begin
         push_entry = imm_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         count_ff <= count_ff + 2'(push) - 2'(pop);
      end
   end

   assign head_entry = fifo_ff[rd_ptr_ff];
   assign rsp_tvalid = count_ff != 2'd0;
   assign rsp_tdata  = {3'b000, head_entry.overflow, head_entry.line_total,
                        head_entry.read_length, head_entry.out_byte};
   assign rsp_tlast  = head_entry.last;
   assign rsp_tuser  = head_entry.accepted;

endmodule

// File: rtl/core/lfo_checker.sv
module lfo_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic        rsp_tlast,
   input logic [0:0]  rsp_tuser
);

   // a stalled beat holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("rsp beat changed while stalled");

   // a put verdict only comes on the closing beat of a step
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tlast && (rsp_tdata[14:8] == 7'd0))
      else $error("accepted flag on a non-final or get beat");

   // an empty ring never reports overflow
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[19:15] == 5'd0) |-> !rsp_tdata[20])
      else $error("overflow set with no lines queued");

   // beats without a line length are single-beat results
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[14:8] == 7'd0) |-> rsp_tlast && (rsp_tdata[7:0] == 8'd0))
      else $error("zero-length beat that is not a single result");

endmodule

bind line_fifo_overwrite_unit lfo_checker u_lfo_checker (.*);

// File: sim/testbench.sv
import lfo_pkg::*;

localparam int LINE_BYTES = 64;
localparam int RING_SLOTS = 16;

typedef struct {
   cmd_type    cmd;
   logic [7:0] data_byte;
   logic [7:0] line_length;
} req_item;

class line_ring_checker;
   logic [7:0]  line_mem [LINE_BYTES*RING_SLOTS];
   logic [7:0]  len_mem [RING_SLOTS];
   int unsigned head;
   int unsigned tail;
   int unsigned queued;
   bit          ovf;
   int unsigned put_idx;
   bit          put_ok;
   logic [6:0]  cap_reg = CAPACITY_RESET;
   logic [4:0]  lines_reg = LINES_RESET;
   bit          lock_reg;
   rsp_type     expected_beats [$];
   int          errors;
   int          beats_seen;

   function int unsigned cap_eff();
      if (cap_reg < 7'd2) return 2;
      if (int'(cap_reg) > LINE_BYTES) return LINE_BYTES;
      return int'(cap_reg);
   endfunction

   function int unsigned lines_eff();
      if (lines_reg < 5'd2) return 2;
      if (int'(lines_reg) > RING_SLOTS) return RING_SLOTS;
      return int'(lines_reg);
   endfunction

   function int unsigned next_slot(int unsigned idx);
      if (idx + 1 >= lines_eff()) return 0;
      return (idx + 1) % RING_SLOTS;
   endfunction

   // line_total and overflow always reflect the state after the update
   function rsp_type make_beat(int b, int len, bit last, bit acc);
      rsp_type r;
      r.out_byte    = 8'(b);
      r.read_length = 7'(len);
      r.last        = last;
      r.accepted    = acc;
      r.line_total  = 5'(queued);
      r.overflow    = ovf;
      return r;
   endfunction

   function int pending();
      return expected_beats.size();
   endfunction

   function void configure(logic [1:0] idx, logic [6:0] value);
      if (idx == CSR_CAPACITY) cap_reg = value;
      else if (idx == CSR_LINES) lines_reg = value[4:0];
      else if (idx == CSR_LOCK) lock_reg = value[0];
   endfunction

   function void note_command(req_item it);
      int unsigned lc;
      int unsigned slot;
      int unsigned stored;
      int unsigned len;
      bit          acc;
      len = int'(it.line_length);
      case (it.cmd)
         CMD_PUT: begin
            lc  = lines_eff();
            acc = 1'b0;
            // admission is decided on the first byte of a line only
            if (put_idx == 0)
               put_ok = (len <= cap_eff()) && !(lock_reg && queued >= lc);
            if (put_ok && put_idx < LINE_BYTES && len != 0)
               line_mem[head*LINE_BYTES + put_idx] = it.data_byte;
            if (put_idx + 1 >= len) begin
               if (put_ok) begin
                  len_mem[head] = it.line_length;
                  if (queued > 0 && head == tail) tail = next_slot(tail);
                  head   = next_slot(head);
                  queued = queued + 1;
                  if (queued > lc) begin
                     queued = lc;
                     ovf    = 1'b1;
                  end
                  acc = 1'b1;
               end
               put_idx = 0;
               put_ok  = 1'b0;
            end else begin
               put_idx = (put_idx + 1) & 255;
            end
            expected_beats.push_back(make_beat(0, 0, 1'b1, acc));
         end
         CMD_GET: begin
            if (queued == 0) begin
               expected_beats.push_back(make_beat(0, 0, 1'b1, 1'b0));
            end else begin
               slot   = tail;
               stored = int'(len_mem[slot]);
               tail   = next_slot(tail);
               if (tail == head) queued = 0;
               else queued = queued - 1;
               if (queued == 0) ovf = 1'b0;
               // bad or empty line gives a single zero beat
               if (stored > cap_eff() || stored == 0) begin
                  expected_beats.push_back(make_beat(0, 0, 1'b1, 1'b0));
               end else begin
                  for (int i = 0; i < stored; i++)
                     expected_beats.push_back(make_beat(int'(line_mem[slot*LINE_BYTES + i]),
                                                        stored, (i + 1 == stored), 1'b0));
               end
            end
         end
         CMD_FLUSH: begin
            head    = 0;
            tail    = 0;
            queued  = 0;
            ovf     = 1'b0;
            put_idx = 0;
            put_ok  = 1'b0;
            expected_beats.push_back(make_beat(0, 0, 1'b1, 1'b0));
         end
         default: begin
            ovf = 1'b0;
            expected_beats.push_back(make_beat(0, 0, 1'b1, 1'b0));
         end
      endcase
   endfunction

   task report(string msg);
      errors++;
      if (errors <= 200) $display("mismatch at beat %0d:%s", beats_seen, msg);
   endtask

   task check_beat(rsp_type got);
      rsp_type want;
      string   diff;
      beats_seen++;
      if (expected_beats.size() == 0) begin
         report($sformatf(" unexpected beat byte %0h len %0d last %0b", got.out_byte,
                          got.read_length, got.last));
         return;
      end
      want = expected_beats.pop_front();
      diff = "";
      if (got.out_byte !== want.out_byte)
         diff = {diff, $sformatf(" out_byte %0h/%0h", got.out_byte, want.out_byte)};
      if (got.read_length !== want.read_length)
         diff = {diff, $sformatf(" read_length %0d/%0d", got.read_length, want.read_length)};
      if (got.last !== want.last)
         diff = {diff, $sformatf(" last %0b/%0b", got.last, want.last)};
      if (got.accepted !== want.accepted)
         diff = {diff, $sformatf(" accepted %0b/%0b", got.accepted, want.accepted)};
      if (got.line_total !== want.line_total)
         diff = {diff, $sformatf(" line_total %0d/%0d", got.line_total, want.line_total)};
      if (got.overflow !== want.overflow)
         diff = {diff, $sformatf(" overflow %0b/%0b", got.overflow, want.overflow)};
      if (diff != "") report({diff, " (got/want)"});
   endtask
endclass

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STALL_LIMIT = 4000;
   localparam int SETTLE_GAP  = 8;
   localparam int HOLD_CYCLES = 300;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;   // data_byte[7:0], line_length[15:8]
   logic [1:0]  req_tuser = '0;   // cmd[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;        // out_byte[7:0], read_length[14:8], line_total[19:15],
                                  // overflow[20], zero[23:21]
   logic        rsp_tlast;        // last
   logic [0:0]  rsp_tuser;        // accepted[0]
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [6:0]  csr_data = '0;

   line_ring_checker sb = new();
   bit calm;
   int rx_hold_left;
   int items_sent;

   line_fifo_overwrite_unit #(
      .MAX_LINE_BYTES(LINE_BYTES),
      .MAX_LINES(RING_SLOTS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast),
      .rsp_tuser(rsp_tuser),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   // result side: check accepted beats, then decide ready for the next edge
   always @(posedge clock) begin : rx_side
      rsp_type beat;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            beat.out_byte    = rsp_tdata[7:0];
            beat.read_length = rsp_tdata[14:8];
            beat.line_total  = rsp_tdata[19:15];
            beat.overflow    = rsp_tdata[20];
            beat.last        = rsp_tlast;
            beat.accepted    = rsp_tuser[0];
            sb.check_beat(beat);
         end
         if (rx_hold_left > 0) begin
            rx_hold_left--;
            rsp_tready <= 1'b0;
         end else if (calm) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= 35);
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("line_fifo_overwrite_unit verification failed");
      $finish;
   end

   task automatic send_item(input cmd_type cmd, input int b, input int len);
      req_item it;
      it.cmd         = cmd;
      it.data_byte   = 8'(b);
      it.line_length = 8'(len);
      while (!calm && $urandom_range(0, 99) < 35) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {it.line_length, it.data_byte};
      req_tuser  <= cmd;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_command(it);
      items_sent++;
   endtask

   // one line of put beats; with noise, a get or a changed length may cut in
   task automatic send_line(input int len, input bit noisy);
      int n;
      n = (len == 0) ? 1 : len;
      for (int k = 0; k < n; k++) begin
         if (noisy && $urandom_range(0, 99) < 4)
            send_item(CMD_GET, $urandom_range(0, 255), $urandom_range(0, 255));
         if (noisy && $urandom_range(0, 99) < 3)
            send_item(CMD_PUT, $urandom_range(0, 255), $urandom_range(0, 255));
         else
            send_item(CMD_PUT, $urandom_range(0, 255), len);
      end
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
      repeat (SETTLE_GAP) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input int value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= 7'(value);
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.configure(idx, 7'(value));
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // a change of ring size is only safe on an empty ring
   task automatic set_config(input int cap, input int lines, input int lock);
      if (5'(lines) != sb.lines_reg) send_item(CMD_FLUSH, 0, 0);
      settle();
      write_reg(CSR_CAPACITY, cap);
      write_reg(CSR_LINES, lines);
      write_reg(CSR_LOCK, lock);
   endtask

   task automatic run_random(input int budget);
      int start;
      int r;
      int q;
      int cap;
      int len;
      start = items_sent;
      while (items_sent - start < budget) begin
         r   = $urandom_range(0, 99);
         cap = sb.cap_eff();
         if (r < 55) begin
            q = $urandom_range(0, 99);
            if (q < 65) len = $urandom_range(0, (cap < 6) ? cap : 6);
            else if (q < 80) len = cap;
            else if (q < 90) len = cap + $urandom_range(1, 3);
            else len = $urandom_range(0, cap);
            send_line(len, 1'b1);
         end else if (r < 75) begin
            send_item(CMD_GET, $urandom_range(0, 255), $urandom_range(0, 255));
         end else if (r < 79) begin
            send_item(CMD_FLUSH, $urandom_range(0, 255), $urandom_range(0, 255));
         end else if (r < 84) begin
            send_item(CMD_CLR_OVF, $urandom_range(0, 255), $urandom_range(0, 255));
         end else if (r < 87) begin
            settle();
         end else begin
            send_item(CMD_PUT, $urandom_range(0, 255), $urandom_range(0, 255));
         end
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // default settings after reset
      send_item(CMD_GET, 8'h00, 0);
      send_item(CMD_PUT, 8'hFF, 0);
      send_item(CMD_GET, 8'hFF, 8'hFF);
      send_item(CMD_PUT, 8'h00, 3);
      send_item(CMD_PUT, 8'hFF, 3);
      send_item(CMD_PUT, 8'h5A, 3);
      send_item(CMD_GET, 8'h00, 0);
      // too long on its first beat, ended early by a zero length
      send_item(CMD_PUT, 8'hC3, 255);
      send_item(CMD_PUT, 8'h3C, 0);
      send_item(CMD_FLUSH, 8'h00, 0);

      // smallest ring and lines, overwrite then lock
      set_config(1, 0, 0);
      repeat (3) send_line(2, 1'b0);
      send_item(CMD_PUT, 8'h81, 3);
      send_item(CMD_PUT, 8'h7E, 1);
      send_item(CMD_CLR_OVF, 8'h00, 0);
      set_config(1, 0, 1);
      send_item(CMD_PUT, 8'h55, 1);
      send_item(CMD_GET, 8'h00, 0);
      send_item(CMD_GET, 8'h00, 0);

      // line stored under a large capacity, read back under a small one
      set_config(64, 2, 0);
      send_line(4, 1'b0);
      set_config(3, 2, 0);
      send_item(CMD_GET, 8'h00, 0);

      set_config(64, 16, 0);
      calm = 1'b1;
      run_random(20);
      settle();
      calm = 1'b0;

      set_config(127, 31, 1);
      rx_hold_left = HOLD_CYCLES;
      run_random(20);

      set_config(5, 3, 0);
      run_random(20);

      set_config(2, 2, 1);
      run_random(20);

      set_config(12, 16, 0);
      run_random(20);

      set_config(0, 1, 0);
      run_random(20);

      settle();
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("line_fifo_overwrite_unit verification clean");
      end else begin
         $display("line_fifo_overwrite_unit verification failed");
      end
      $finish;
   end
endmodule
